>>> sv/spmf_pkg.sv
// spmf_pkg: shared types, codes and defaults for the strict priority multi-FIFO.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spmf_pkg;

  localparam int NUM_PRIORITIES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int DATA_WIDTH_DEF     = 32;

  localparam int PRIO_W      = 2;
  localparam int WORD_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] prio;
    logic              hit;
  } resp_t;

endpackage

>>> sv/spmf_ctrl.sv
// spmf_ctrl: per-ring head/tail pointers, fill counts and the pop priority encoder.
// Depends on spmf_pkg; drives the store module's write/read controls.
`timescale 1ns / 1ps

module spmf_ctrl import spmf_pkg::*; #(
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  localparam int PIDX_W = $clog2(NUM_PRIORITIES),
  localparam int PTR_W  = $clog2(QUEUE_DEPTH),
  localparam int ADDR_W = PIDX_W + PTR_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  req_t              req_type,
  input  logic [PRIO_W-1:0] push_priority,
  output mem_ctl_t          mem_ctl,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] rd_addr,
  output resp_t             resp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] head_r [NUM_PRIORITIES];
  logic [PTR_W-1:0] head_nxt [NUM_PRIORITIES];
  logic [PTR_W-1:0] tail_r [NUM_PRIORITIES];
  logic [PTR_W-1:0] tail_nxt [NUM_PRIORITIES];
  logic [CNT_W-1:0] cnt_r [NUM_PRIORITIES];
  logic [CNT_W-1:0] cnt_nxt [NUM_PRIORITIES];

  logic              in_range;
  logic [PIDX_W-1:0] push_idx;
  logic              push_ok;
  logic              any_ne;
  logic [PIDX_W-1:0] sel;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign in_range = (32'(push_priority) < NUM_PRIORITIES);
  assign push_idx = PIDX_W'(push_priority);
  assign push_ok  = in_range && (cnt_r[push_idx] != CNT_W'(QUEUE_DEPTH));

  // fixed priority: lowest index that holds a word
  always_comb begin
    any_ne = 1'b0;
    sel    = '0;
    for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        any_ne = 1'b1;
        sel    = PIDX_W'(i);
      end
    end
  end

  assign wr_addr = {push_idx, tail_r[push_idx]};
  assign rd_addr = {sel, head_r[sel]};

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    resp.status   = ST_OK;
    resp.prio     = '0;
    resp.hit      = 1'b0;
    if (req_type == REQ_PUSH) begin
      if (!push_ok) begin
        resp.status = ST_FULL;
      end else if (accept) begin
        mem_ctl.wr_en      = 1'b1;
        tail_nxt[push_idx] = wrap_inc(tail_r[push_idx]);
        cnt_nxt[push_idx]  = cnt_r[push_idx] + CNT_W'(1);
      end
    end else begin
      if (!any_ne) begin
        resp.status = ST_EMPTY;
      end else begin
        resp.prio = PRIO_W'(sel);
        resp.hit  = 1'b1;
        if (accept) begin
          mem_ctl.rd_en = 1'b1;
          head_nxt[sel] = wrap_inc(head_r[sel]);
          cnt_nxt[sel]  = cnt_r[sel] - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> sv/spmf_store.sv
// spmf_store: message word memory shared by all rings, one write and one read port.
// Depends on spmf_pkg; read data is registered.
`timescale 1ns / 1ps

module spmf_store import spmf_pkg::*; #(
  parameter int ADDR_W     = 4,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  mem_ctl_t              mem_ctl,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [2**ADDR_W];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/strict_priority_multi_fifo_unit.sv
// strict_priority_multi_fifo_unit: top level of the strict priority multi-FIFO.
// Depends on spmf_pkg, spmf_ctrl and spmf_store.
//
//  channel  | dir | tdata (low bit up)                  | tuser
//  in_      | in  | push_priority[1:0], push_data[33:2] | req_type[0]
//  out_     | out | pop_priority[1:0], pop_data[33:2]   | status[1:0]
//
// One request per cycle while no result waits with out_tready low; its result is valid in the cycle after acceptance.
// Pop data comes from the store's registered read port, loaded at acceptance.
// in_tready is low in reset and while a result waits with out_tready low.
// Reset empties every ring; stored words are not cleared.
`timescale 1ns / 1ps

module strict_priority_multi_fifo_unit import spmf_pkg::*; #(
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // push_priority, push_data
  input  logic [0:0]             in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pop_priority, pop_data
  output logic [1:0]             out_tuser   // status
);

  localparam int ADDR_W = $clog2(NUM_PRIORITIES) + $clog2(QUEUE_DEPTH);

  logic                  accept;
  req_t                  req_type;
  logic [PRIO_W-1:0]     push_priority;
  logic [WORD_W-1:0]     push_data;
  mem_ctl_t              mem_ctl;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  resp_t                 resp;
  resp_t                 resp_r;
  logic                  out_tvalid_r;
  logic [WORD_W-1:0]     pop_data;

  assign req_type      = req_t'(in_tuser[0]);
  assign push_priority = in_tdata[PRIO_W-1:0];
  assign push_data     = in_tdata[PRIO_W+WORD_W-1:PRIO_W];

  assign in_tready = rst_n && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  spmf_ctrl #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .req_type      (req_type),
    .push_priority (push_priority),
    .mem_ctl       (mem_ctl),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .resp          (resp)
  );

  spmf_store #(
    .ADDR_W     (ADDR_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (DATA_WIDTH'(push_data)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_tready) begin
      out_tvalid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp_r <= resp;
    end
  end

  assign pop_data   = resp_r.hit ? WORD_W'(rd_data) : '0;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = resp_r.status;
  assign out_tdata  = {(OUT_TDATA_W - PRIO_W - WORD_W)'(0), pop_data, resp_r.prio};

endmodule

>>> sv/spmf_checker.sv
// spmf_checker: port-level assertions for strict_priority_multi_fifo_unit.
// Depends on spmf_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module spmf_checker import spmf_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [0:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request gave no result");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("non-ok result carries data");

  a_first_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && in_tvalid && in_tready && in_tuser[0] == REQ_POP
      |=> out_tuser == ST_EMPTY)
    else $error("pop right after reset not empty");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request refused with output free");

endmodule

bind strict_priority_multi_fifo_unit spmf_checker u_spmf_checker (.*);

>>> tb/tb_strict_priority_multi_fifo_unit.sv
// tb_strict_priority_multi_fifo_unit: directed table plus random push/pop traffic for the
// strict priority multi-FIFO, checked against an in-bench ring predictor.
// Depends on spmf_pkg and strict_priority_multi_fifo_unit.
`timescale 1ns / 1ps

module tb_strict_priority_multi_fifo_unit;
  import spmf_pkg::*;

  localparam int NPRIO          = 4;
  localparam int DEPTH          = 4;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    status_t           status;
    logic [PRIO_W-1:0] prio;
    logic [WORD_W-1:0] word;
  } reply_t;

  typedef struct {
    req_t              req;
    logic [PRIO_W-1:0] prio;
    logic [WORD_W-1:0] word;
    bit                fixed;
    reply_t            typed;
  } script_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // push_priority, push_data
  logic [0:0]             in_tuser;   // req_type
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // pop_priority, pop_data
  logic [1:0]             out_tuser;  // status

  logic [WORD_W-1:0] ring_word [NPRIO][DEPTH];
  logic [1:0]        ring_head [NPRIO];
  logic [1:0]        ring_tail [NPRIO];
  logic [2:0]        ring_fill [NPRIO];

  reply_t      pending_replies[$];
  script_row_t script[$];
  bit          idle_on;
  int          fail_count;
  int          n_push, n_pop, n_full, n_empty, n_checked;
  int          stall_left;
  int          quiet_cycles;

  strict_priority_multi_fifo_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Ring predictor: applies one request and returns the reply it causes.
  task automatic predict_ring_result(input req_t req, input logic [PRIO_W-1:0] prio,
                                     input logic [WORD_W-1:0] word, output reply_t rep);
    bit found;
    rep.status = ST_OK;
    rep.prio   = '0;
    rep.word   = '0;
    found      = 1'b0;
    if (req == REQ_PUSH) begin
      n_push++;
      if (int'(prio) >= NPRIO || ring_fill[prio] >= DEPTH) begin
        rep.status = ST_FULL;
        n_full++;
      end else begin
        ring_word[prio][ring_tail[prio]] = word;
        ring_tail[prio] = (ring_tail[prio] == DEPTH - 1) ? 2'd0 : ring_tail[prio] + 2'd1;
        ring_fill[prio]++;
      end
    end else begin
      n_pop++;
      for (int p = 0; p < NPRIO; p++) begin
        if (!found && ring_fill[p] != 0) begin
          found    = 1'b1;
          rep.prio = p[PRIO_W-1:0];
          rep.word = ring_word[p][ring_head[p]];
          ring_head[p] = (ring_head[p] == DEPTH - 1) ? 2'd0 : ring_head[p] + 2'd1;
          ring_fill[p]--;
        end
      end
      if (!found) begin
        rep.status = ST_EMPTY;
        n_empty++;
      end
    end
  endtask

  task automatic send_request(input req_t req, input logic [PRIO_W-1:0] prio,
                              input logic [WORD_W-1:0] word, input bit fixed,
                              input reply_t typed);
    int     gap;
    reply_t want;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_TDATA_W - WORD_W - PRIO_W){1'b0}}, word, prio};
    do @(posedge clk); while (!in_tready);
    predict_ring_result(req, prio, word, want);
    if (fixed) want = typed;
    pending_replies.push_back(want);
  endtask

  task automatic add_row(input req_t req, input logic [PRIO_W-1:0] prio,
                         input logic [WORD_W-1:0] word, input bit fixed,
                         input status_t st, input logic [PRIO_W-1:0] rprio,
                         input logic [WORD_W-1:0] rword);
    script_row_t row;
    row.req          = req;
    row.prio         = prio;
    row.word         = word;
    row.fixed        = fixed;
    row.typed.status = st;
    row.typed.prio   = rprio;
    row.typed.word   = rword;
    script.push_back(row);
  endtask

  // Result stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(7) == 0) begin
      stall_left <= ($urandom_range(15) == 0) ? $urandom_range(40, 8) : $urandom_range(2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("result with no request outstanding: status %0d prio %0d word %08h",
               out_tuser, out_tdata[1:0], out_tdata[33:2]);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        n_checked++;
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[1:0] !== want.prio) begin
          $error("pop_priority: expected %0d, got %0d", want.prio, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[33:2] !== want.word) begin
          $error("pop_data: expected %08h, got %08h", want.word, out_tdata[33:2]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("strict_priority_multi_fifo_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          push_pct;
    req_t        req;
    logic [1:0]  prio;
    logic [31:0] word;
    reply_t      none;

    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tuser     <= '0;
    in_tdata     <= '0;
    idle_on      = 1'b0;
    fail_count   = 0;
    n_push = 0; n_pop = 0; n_full = 0; n_empty = 0; n_checked = 0;
    none.status = ST_OK;
    none.prio   = '0;
    none.word   = '0;
    for (int p = 0; p < NPRIO; p++) begin
      ring_head[p] = '0;
      ring_tail[p] = '0;
      ring_fill[p] = '0;
    end

    // empty after reset, fill ring 3 to full, priority order, pointer wrap
    add_row(REQ_POP,  2'd3, 32'hFFFF_FFFF, 1, ST_EMPTY, 2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd3, 32'hFFFF_FFFF, 1, ST_OK,    2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd3, 32'h0000_0000, 0, ST_OK,    2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd3, 32'hA5A5_A5A5, 0, ST_OK,    2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd3, 32'h5A5A_5A5A, 0, ST_OK,    2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd3, 32'h1234_5678, 1, ST_FULL,  2'd0, 32'h0);
    add_row(REQ_POP,  2'd0, 32'h0000_0000, 1, ST_OK,    2'd3, 32'hFFFF_FFFF);
    add_row(REQ_PUSH, 2'd0, 32'h0000_0001, 1, ST_OK,    2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd1, 32'h8000_0000, 1, ST_OK,    2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd2, 32'h7FFF_FFFF, 0, ST_OK,    2'd0, 32'h0);
    add_row(REQ_POP,  2'd0, 32'h0,         0, ST_OK,    2'd0, 32'h0);
    add_row(REQ_POP,  2'd0, 32'h0,         0, ST_OK,    2'd0, 32'h0);
    add_row(REQ_POP,  2'd0, 32'h0,         0, ST_OK,    2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd3, 32'hDEAD_BEEF, 0, ST_OK,    2'd0, 32'h0);
    for (int i = 0; i < 4; i++)
      add_row(REQ_POP, 2'd1, 32'hFFFF_FFFF, 0, ST_OK, 2'd0, 32'h0);
    add_row(REQ_POP,  2'd2, 32'h0,         1, ST_EMPTY, 2'd0, 32'h0);
    for (int i = 0; i < 4; i++)
      add_row(REQ_PUSH, 2'd0, 32'hFFFF_FFFF, 0, ST_OK, 2'd0, 32'h0);
    add_row(REQ_PUSH, 2'd0, 32'h0000_0000, 1, ST_FULL,  2'd0, 32'h0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      send_request(script[i].req, script[i].prio, script[i].word, script[i].fixed,
                   script[i].typed);

    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        idle_on = ($urandom_range(3) != 0);
      end
      req  = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
      prio = PRIO_W'($urandom_range(NPRIO - 1));
      case ($urandom_range(15))
        0:       word = 32'h0;
        1:       word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      send_request(req, prio, word, 1'b0, none);
    end
    in_tvalid <= 1'b0;
    idle_on   = 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d pushes (%0d rejected full) and %0d pops (%0d empty)",
             n_push, n_full, n_pop, n_empty);
    $display("%0d results checked, %0d field mismatches", n_checked, fail_count);
    if (fail_count == 0)
      $display("strict_priority_multi_fifo_unit regression: pass");
    else
      $display("strict_priority_multi_fifo_unit regression: fail");
    $finish;
  end

endmodule

>>> files.f
sv/spmf_pkg.sv
sv/spmf_ctrl.sv
sv/spmf_store.sv
sv/strict_priority_multi_fifo_unit.sv
sv/spmf_checker.sv
tb/tb_strict_priority_multi_fifo_unit.sv
